FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define PAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pas: same-cycle check failed");

// Next-cycle implication, muted while reset is high.
`define PAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pas: next-cycle check failed");

// Next-cycle implication, checked through reset as well.
`define PAS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pas: reset check failed");

`endif

FILE: src/pas_pkg.sv
// Shared constants, types and the arctangent table of the polyline simplifier.
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int THRESH_WIDTH = 16;
  localparam int TABLE_LEN    = 24;
  localparam int TABLE_IDX_W  = $clog2(TABLE_LEN);
  localparam int PADDR_WIDTH  = 3;
  localparam int PDATA_WIDTH  = 32;

  localparam logic                    SIMPLIFY_RESET = 1'b1;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET   = 16'd2731;

  localparam logic REG_SIMPLIFY_ENABLE = 1'b0;
  localparam logic REG_ANGLE_THRESHOLD = 1'b1;

  typedef struct packed {
    logic prev_from_in;
    logic seg_start;
    logic rot_step;
    logic lsa_load;
    logic prev_from_cur;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic dup;
    logic keep;
    logic slot_free;
  } stat_t;

  function automatic logic [31:0] atan_turn(input logic [TABLE_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/pas_point_if.sv
// Input channel: one pen point per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pas_point_if #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic                          stroke_end;

  modport source (output valid, output pos_x, output pos_y, output stroke_end, input ready);
  modport sink (input valid, input pos_x, input pos_y, input stroke_end, output ready);
endinterface

`default_nettype wire

FILE: src/pas_result_if.sv
// Output channel: one kept point per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pas_result_if #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          out_last;

  modport source (output valid, output out_x, output out_y, output out_last, input ready);
  modport sink (input valid, input out_x, input out_y, input out_last, output ready);
endinterface

`default_nettype wire

FILE: src/pas_ctrl.sv
// Controller: stroke phase, CORDIC step count and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module pas_ctrl #(
  parameter int CORDIC_STEPS = pas_pkg::CORDIC_STEPS,
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_end,
  output logic           in_ready,
  input  pas_pkg::stat_t stat,
  output pas_pkg::cmd_t  cmd,
  output logic [SW-1:0]  step
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTATE,
    S_DECIDE,
    S_EMIT_HELD,
    S_EMIT_END
  } state_t;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_MANY
  } phase_t;

  state_t state;
  phase_t phase;
  logic   end_flag;
  logic   first_seg;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (phase == PH_EMPTY) begin
            cmd.prev_from_in = 1'b1;
          end else if (!stat.dup) begin
            cmd.seg_start = 1'b1;
          end
        end
      end
      S_ROTATE: begin
        cmd.rot_step = 1'b1;
      end
      S_DECIDE: begin
        cmd.lsa_load = 1'b1;
        if (!(first_seg || stat.keep)) begin
          cmd.prev_from_cur = 1'b1;
        end
      end
      S_EMIT_HELD: begin
        if (stat.slot_free) begin
          cmd.out_load      = 1'b1;
          cmd.prev_from_cur = 1'b1;
        end
      end
      S_EMIT_END: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_EMPTY;
      step      <= '0;
      end_flag  <= 1'b0;
      first_seg <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase == PH_EMPTY) begin
              phase <= in_end ? PH_EMPTY : PH_ONE;
            end else if (stat.dup) begin
              if (in_end) begin
                phase <= PH_EMPTY;
                if (phase == PH_MANY) begin
                  state <= S_EMIT_END;
                end
              end
            end else begin
              end_flag  <= in_end;
              first_seg <= (phase == PH_ONE);
              step      <= '0;
              state     <= S_ROTATE;
            end
          end
        end
        S_ROTATE: begin
          step <= step + 1'b1;
          if (step == SW'(CORDIC_STEPS - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          phase <= PH_MANY;
          if (first_seg || stat.keep) begin
            state <= S_EMIT_HELD;
          end else if (end_flag) begin
            state <= S_EMIT_END;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_HELD: begin
          if (stat.slot_free) begin
            state <= end_flag ? S_EMIT_END : S_IDLE;
          end
        end
        S_EMIT_END: begin
          if (stat.slot_free) begin
            phase <= PH_EMPTY;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/pas_dp.sv
// Datapath: held point, CORDIC vectoring unit, angle compare and output register.
`timescale 1ns / 1ps
`default_nettype none

module pas_dp #(
  parameter int COORD_WIDTH  = pas_pkg::COORD_WIDTH,
  parameter int ANGLE_BITS   = pas_pkg::ANGLE_BITS,
  parameter int CORDIC_STEPS = pas_pkg::CORDIC_STEPS,
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [COORD_WIDTH-1:0]       in_x,
  input  logic signed [COORD_WIDTH-1:0]       in_y,
  input  pas_pkg::cmd_t                       cmd,
  input  logic [SW-1:0]                       step,
  input  logic                                simplify_enable,
  input  logic [pas_pkg::THRESH_WIDTH-1:0]    angle_threshold,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic                                out_last,
  output pas_pkg::stat_t                      stat
);

  localparam int W    = COORD_WIDTH + 3;
  localparam int CMPW = (ANGLE_BITS > pas_pkg::THRESH_WIDTH) ? ANGLE_BITS
                                                             : pas_pkg::THRESH_WIDTH;
  localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;
  logic signed [COORD_WIDTH-1:0] cur_x;
  logic signed [COORD_WIDTH-1:0] cur_y;
  logic [ANGLE_BITS-1:0]         lsa;
  logic signed [W-1:0]           cx;
  logic signed [W-1:0]           cy;
  logic [31:0]                   cz;

  logic signed [W-1:0]   dx;
  logic signed [W-1:0]   dy;
  logic signed [W-1:0]   xs;
  logic signed [W-1:0]   ys;
  logic [31:0]           turn;
  logic [31:0]           z_round;
  logic [ANGLE_BITS-1:0] angle;
  logic [ANGLE_BITS-1:0] diff;

  assign dx = W'(in_x) - W'(prev_x);
  assign dy = W'(in_y) - W'(prev_y);
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign turn = pas_pkg::atan_turn(pas_pkg::TABLE_IDX_W'(step));

  assign z_round = cz + ROUND_HALF;
  assign angle   = z_round[31 -: ANGLE_BITS];
  assign diff    = (angle > lsa) ? (angle - lsa) : (lsa - angle);

  assign stat.dup       = (in_x == prev_x) && (in_y == prev_y);
  assign stat.keep      = !(simplify_enable && (CMPW'(diff) < CMPW'(angle_threshold)));
  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.prev_from_in) begin
      prev_x <= in_x;
      prev_y <= in_y;
    end else if (cmd.prev_from_cur) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.seg_start) begin
      cur_x <= in_x;
      cur_y <= in_y;
      if (dx < 0) begin
        cx <= -dx;
        cy <= -dy;
        cz <= HALF_TURN;
      end else begin
        cx <= dx;
        cy <= dy;
        cz <= '0;
      end
    end else if (cmd.rot_step) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + turn;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - turn;
      end
    end
    if (cmd.lsa_load) begin
      lsa <= angle;
    end
    if (cmd.out_load) begin
      out_x    <= prev_x;
      out_y    <= prev_y;
      out_last <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: src/polyline_angle_simplifier.sv
// Top level of the polyline angle simplifier: channels, register port, controller, datapath.
// Usage:
//   points (valid/ready) takes one pen point per beat: pos_x, pos_y, stroke_end.
//   results (valid/ready) gives kept points: out_x, out_y, out_last.
//   APB registers: 0x0 simplify_enable, 0x4 angle_threshold (2^-16 turn units).
// Sequence:
//   The first point of a stroke and a duplicate point are taken while idle; a
//   duplicate that ends a stroke of two or more points then emits the held point as last.
//   Any other point runs CORDIC_STEPS iterations of one shared CORDIC unit,
//   one per cycle, then a decision step and one result step per result,
//   each result step waiting until the result register is free.
//   One point is worked on at a time; points.ready is high only while idle.
//   Up to two results per point: the released held point, then the final
//   point of the stroke with out_last set.
// Reset (synchronous, active high) empties the stroke, drops any pending
//   result and restores the register defaults (enabled, 2731).
// A stalled receiver holds the result register; the block waits for it
//   before loading the next result and keeps points.ready low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module polyline_angle_simplifier #(
  parameter int COORD_WIDTH  = pas_pkg::COORD_WIDTH,
  parameter int ANGLE_BITS   = pas_pkg::ANGLE_BITS,
  parameter int CORDIC_STEPS = pas_pkg::CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst,
  pas_point_if.sink                         points,
  pas_result_if.source                      results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pas_pkg::PADDR_WIDTH-1:0]   paddr,
  input  logic [pas_pkg::PDATA_WIDTH-1:0]   pwdata,
  output logic [pas_pkg::PDATA_WIDTH-1:0]   prdata,
  output logic                              pready
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic                               simplify_enable;
  logic [pas_pkg::THRESH_WIDTH-1:0]   angle_threshold;
  logic                               wr_en;
  pas_pkg::cmd_t                      cmd;
  pas_pkg::stat_t                     stat;
  logic [SW-1:0]                      step;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      simplify_enable <= pas_pkg::SIMPLIFY_RESET;
      angle_threshold <= pas_pkg::THRESH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        pas_pkg::REG_SIMPLIFY_ENABLE: simplify_enable <= pwdata[0];
        pas_pkg::REG_ANGLE_THRESHOLD: angle_threshold <= pwdata[pas_pkg::THRESH_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pas_pkg::REG_SIMPLIFY_ENABLE:
        prdata = pas_pkg::PDATA_WIDTH'(simplify_enable);
      pas_pkg::REG_ANGLE_THRESHOLD:
        prdata = pas_pkg::PDATA_WIDTH'(angle_threshold);
      default:
        prdata = '0;
    endcase
  end

  pas_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_end   (points.stroke_end),
    .in_ready (points.ready),
    .stat     (stat),
    .cmd      (cmd),
    .step     (step)
  );

  pas_dp #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_x            (points.pos_x),
    .in_y            (points.pos_y),
    .cmd             (cmd),
    .step            (step),
    .simplify_enable (simplify_enable),
    .angle_threshold (angle_threshold),
    .out_ready       (results.ready),
    .out_valid       (results.valid),
    .out_x           (results.out_x),
    .out_y           (results.out_y),
    .out_last        (results.out_last),
    .stat            (stat)
  );

endmodule

`default_nettype wire

FILE: src/pas_checker.sv
// Port-level checker for the polyline angle simplifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pas_checker #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [COORD_WIDTH-1:0] res_x,
  input logic [COORD_WIDTH-1:0] res_y,
  input logic                   res_last
);

  `PAS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_x) && $stable(res_y) && $stable(res_last))
  `PAS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !res_valid && in_ready)
  `PAS_ASSERT_IMPL(a_result_from_busy, clk, rst, $rose(res_valid), !$past(in_ready))

endmodule

bind polyline_angle_simplifier pas_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_pas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (points.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_x     (results.out_x),
  .res_y     (results.out_y),
  .res_last  (results.out_last)
);

`default_nettype wire

FILE: verif/pas_stroke_checker.sv
// Checker for the polyline angle simplifier: tracks register writes, predicts kept points and compares them.
`timescale 1ns / 1ps

module pas_stroke_checker
  import pas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  pas_point_if                   points,
  pas_result_if                  results,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output int                     fail_count,
  output int                     pending_count,
  output int                     results_checked
);

  typedef enum logic [1:0] {STROKE_EMPTY, STROKE_ONE, STROKE_MANY} stroke_phase_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          last;
  } kept_point_t;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331, 32'd21354465,
    32'd10679838,  32'd5340245,   32'd2670163,   32'd1335087,  32'd667544,   32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,    32'd10430,    32'd5215,
    32'd2608,      32'd1304,      32'd652,       32'd326,      32'd163,      32'd81
  };

  kept_point_t                   kept_q[$];
  logic                          simplify_on;
  logic [THRESH_WIDTH-1:0]       combine_thresh;
  logic signed [COORD_WIDTH-1:0] held_x;
  logic signed [COORD_WIDTH-1:0] held_y;
  stroke_phase_e                 phase;
  logic [ANGLE_BITS-1:0]         held_heading;
  int                            errors;
  int                            checked;

  function automatic logic [ANGLE_BITS-1:0] segment_heading(
    input logic signed [COORD_WIDTH-1:0] ax,
    input logic signed [COORD_WIDTH-1:0] ay,
    input logic signed [COORD_WIDTH-1:0] bx,
    input logic signed [COORD_WIDTH-1:0] by
  );
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] turn;
    x = longint'(bx) - longint'(ax);
    y = longint'(by) - longint'(ay);
    turn = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      turn = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        turn = turn + ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        turn = turn - ATAN_TURNS[i];
      end
    end
    turn = turn + (32'd1 << (31 - ANGLE_BITS));
    return turn[31 -: ANGLE_BITS];
  endfunction

  function automatic void predict_point(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic                          fin
  );
    logic [ANGLE_BITS-1:0] heading;
    logic [ANGLE_BITS-1:0] diff;
    if (phase == STROKE_EMPTY) begin
      held_x = px;
      held_y = py;
      phase = fin ? STROKE_EMPTY : STROKE_ONE;
      return;
    end
    if (px == held_x && py == held_y) begin
      if (fin) begin
        if (phase == STROKE_MANY) kept_q.push_back(kept_point_t'{held_x, held_y, 1'b1});
        phase = STROKE_EMPTY;
      end
      return;
    end
    heading = segment_heading(held_x, held_y, px, py);
    diff = (heading > held_heading) ? heading - held_heading : held_heading - heading;
    if (phase == STROKE_ONE || !(simplify_on && diff < combine_thresh))
      kept_q.push_back(kept_point_t'{held_x, held_y, 1'b0});
    held_heading = heading;
    held_x = px;
    held_y = py;
    phase = STROKE_MANY;
    if (fin) begin
      kept_q.push_back(kept_point_t'{px, py, 1'b1});
      phase = STROKE_EMPTY;
    end
  endfunction

  always @(posedge clk) begin
    kept_point_t want;
    if (rst) begin
      simplify_on = SIMPLIFY_RESET;
      combine_thresh = THRESH_RESET;
      held_x = '0;
      held_y = '0;
      phase = STROKE_EMPTY;
      held_heading = '0;
      kept_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[PADDR_WIDTH-1:2] == REG_SIMPLIFY_ENABLE) begin
          simplify_on = pwdata[0];
        end else if (paddr[PADDR_WIDTH-1:2] == REG_ANGLE_THRESHOLD) begin
          combine_thresh = pwdata[THRESH_WIDTH-1:0];
        end
      end
      if (results.valid && results.ready) begin
        if (kept_q.size() == 0) begin
          $error("kept point (%0d, %0d) last=%0b arrived with none expected",
                 results.out_x, results.out_y, results.out_last);
          errors++;
        end else begin
          want = kept_q.pop_front();
          checked++;
          if (results.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, results.out_x);
            errors++;
          end
          if (results.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, results.out_y);
            errors++;
          end
          if (results.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, results.out_last);
            errors++;
          end
        end
      end
      if (points.valid && points.ready)
        predict_point(points.pos_x, points.pos_y, points.stroke_end);
    end
    fail_count <= errors;
    pending_count <= kept_q.size();
    results_checked <= checked;
  end

endmodule

FILE: verif/tb_polyline_angle_simplifier.sv
// Testbench top for the polyline angle simplifier: clock, reset, stroke stimulus and verdict.
`timescale 1ns / 1ps

module tb_polyline_angle_simplifier;
  import pas_pkg::*;

  localparam int CW            = COORD_WIDTH;
  localparam int SETTLE_CYCLES = 2 * (CORDIC_STEPS + 4);
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_POINTS  = 67;
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [PDATA_WIDTH-1:0] pwdata;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 56;
  bit          hold_req      = 1'b0;
  int          fail_count;
  int          pending_count;
  int          results_checked;
  int          points_sent;
  int          strokes_sent;
  int          settings_used;

  pas_point_if  pts_if ();
  pas_result_if res_if ();

  always #5 clk = ~clk;

  polyline_angle_simplifier u_top (
    .clk     (clk),
    .rst     (rst),
    .points  (pts_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pas_stroke_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .points          (pts_if),
    .results         (res_if),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  initial begin
    bit hold_ack;
    int hold_left;
    hold_ack = 1'b0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** polyline_angle_simplifier: FAILED **");
    $finish;
  end

  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      pts_if.valid <= 1'b0;
      @(posedge clk);
    end
    pts_if.valid <= 1'b1;
    pts_if.pos_x <= x;
    pts_if.pos_y <= y;
    pts_if.stroke_end <= last;
    @(posedge clk);
    while (!pts_if.ready) @(posedge clk);
    points_sent++;
    if (last) strokes_sent++;
  endtask

  task automatic settle();
    pts_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_WIDTH-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_WIDTH'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int rand_step(input int scale);
    return int'($urandom_range(2 << scale, 0)) - (1 << scale);
  endfunction

  task automatic send_stroke();
    int                    n;
    int                    scale;
    int                    r;
    int                    dx;
    int                    dy;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    n = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(12, 2);
    scale = ($urandom_range(3, 0) == 0) ? $urandom_range(22, 11) : $urandom_range(10, 1);
    if ($urandom_range(3, 0) == 0) begin
      x = CW'($urandom);
      y = CW'($urandom);
    end else begin
      x = CW'(int'($urandom_range(4095, 0)) - 2048);
      y = CW'(int'($urandom_range(4095, 0)) - 2048);
    end
    dx = rand_step(scale);
    dy = rand_step(scale);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        r = $urandom_range(99, 0);
        if (r >= 8 && r < 14) begin
          x = CW'($urandom);
          y = CW'($urandom);
        end else if (r >= 14) begin
          if (r < 35) begin
            dx = rand_step(scale);
            dy = rand_step(scale);
          end else begin
            dx = dx + int'($urandom_range(6, 0)) - 3;
            dy = dy + int'($urandom_range(6, 0)) - 3;
          end
          x = x + CW'(dx);
          y = y + CW'(dy);
        end
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    logic                   en;
    logic [THRESH_WIDTH-1:0] thr;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pts_if.valid = 1'b0;
    pts_if.pos_x = '0;
    pts_if.pos_y = '0;
    pts_if.stroke_end = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_point(5, -5, 1'b1);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1000, 10, 1'b0);
    send_point(2000, 20, 1'b0);
    send_point(3000, 15, 1'b0);
    send_point(4000, 5, 1'b0);
    send_point(5000, -5, 1'b0);
    send_point(5000, 1000, 1'b1);
    send_point(100, 100, 1'b0);
    send_point(-100, 100, 1'b0);
    send_point(-100, -100, 1'b0);
    send_point(-100, -300, 1'b1);
    send_point(1, 2, 1'b0);
    send_point(-3, 4, 1'b1);
    settle();
    settings_used = 1;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin en = 1'b1; thr = THRESH_RESET; end
        1: begin en = 1'b0; thr = '1; end
        2: begin en = 1'b1; thr = '0; end
        3: begin en = 1'b1; thr = '1; end
        4: begin en = 1'b1; thr = THRESH_WIDTH'($urandom); end
        default: begin en = 1'b1; thr = THRESH_WIDTH'($urandom_range(8000, 0)); end
      endcase
      send_idle_pct = (p < 2) ? 15 : (p < 4) ? 56 : 0;
      recv_idle_pct <= (p < 2) ? 56 : (p < 4) ? 15 : 0;
      write_reg(REG_SIMPLIFY_ENABLE, PDATA_WIDTH'(en));
      write_reg(REG_ANGLE_THRESHOLD, PDATA_WIDTH'(thr));
      settings_used++;
      if (p == 1 || p == 3) begin
        send_stroke();
        hold_req <= ~hold_req;
      end
      while (points_sent < 23 + PHASE_POINTS * (p + 1)) send_stroke();
      settle();
    end

    $display("Covered %0d pen points in %0d strokes over %0d register settings;",
             points_sent, strokes_sent, settings_used);
    $display("%0d kept points checked, with sender and receiver idling and a long stall.",
             results_checked);
    if (pending_count != 0) $error("%0d expected kept points never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** polyline_angle_simplifier: PASSED **");
    end else begin
      $display("** polyline_angle_simplifier: FAILED **");
    end
    $finish;
  end

endmodule
